// ===== sv/double_ended_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int W_WORD    = 32;
    localparam int W_OPC     = 3;
    localparam int W_STAT    = 2;
    localparam int W_OCC     = 5;

    typedef enum logic [W_OPC-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_opcode;

    typedef enum logic [W_STAT-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

endpackage

// ===== sv/double_ended_queue_core.sv =====
// Push, refused push, empty pop/list and unknown opcodes: result registered at the accept edge.
// Pop: read-data register at accept, then the output register; input held off meanwhile.
// Push and the other cases above: one word per cycle while the output is taken.
// List of N elements: one memory read per element; input held off meanwhile.
// Reset (synchronous, active low) empties the queue; store contents are left as they are.
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of signed 32-bit words in a ring store with front index and
// element count. Push/pop at either end, plus a front-to-back list walk.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [deq_pkg::W_OPC-1:0]         i_opcode,
    input  logic signed [deq_pkg::W_WORD-1:0] i_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [deq_pkg::W_WORD-1:0] o_word,
    output logic [deq_pkg::W_STAT-1:0]        o_status,
    output logic                              o_last,
    output logic [deq_pkg::W_OCC-1:0]         o_occupancy
);

    // index into the ring, and count that can hold DEPTH itself
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // count widened to at least the occupancy port, so the mask is a plain slice
    localparam int XW = (CW > deq_pkg::W_OCC) ? CW : deq_pkg::W_OCC;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    deq_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx,   n_idx;      // list walk position, offset from front

    // ring store: one port, one access per cycle, registered read data
    logic [deq_pkg::W_WORD-1:0] r_mem [DEPTH];
    logic [deq_pkg::W_WORD-1:0] r_rd_data;
    logic                       rd_en;
    logic                       wr_en;
    logic [IW-1:0]              mem_addr;

    // output register
    logic                              r_out_valid;
    logic signed [deq_pkg::W_WORD-1:0] r_word;
    logic [deq_pkg::W_STAT-1:0]        r_status;
    logic                              r_last;
    logic [deq_pkg::W_OCC-1:0]         r_occ;

    logic                       load_out;
    logic [deq_pkg::W_WORD-1:0] n_word;
    deq_pkg::t_status           n_status;
    logic                       n_last;
    logic [XW-1:0]              occ_x;

    // ------------------------------------------------------------------
    // Ring arithmetic
    // ------------------------------------------------------------------
    logic          out_free;
    logic          in_acc;
    logic          is_full;
    logic          is_empty;
    logic          list_done;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] slot_off;
    logic [IW:0]   slot_sum;
    logic [IW-1:0] slot_addr;

    assign out_free  = !r_out_valid || i_ready;
    assign in_acc    = i_valid && o_ready;
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    // current list element is the back one
    assign list_done = ((CW'(r_idx) + CW'(1)) == r_count);

    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // one shared slot adder: front + offset, wrapped once
    always_comb begin
        if (r_state == deq_pkg::S_LIST) begin
            slot_off = r_idx + 1'b1;
        end else if (i_opcode == deq_pkg::OP_PUSH_BACK) begin
            slot_off = IW'(r_count);
        end else begin
            slot_off = IW'(r_count - 1'b1);
        end
    end

    assign slot_sum  = {1'b0, r_front} + {1'b0, slot_off};
    assign slot_addr = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                                    : slot_sum[IW-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode) inside
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            if (!is_empty) n_state = deq_pkg::S_POP;
                        end
                        deq_pkg::OP_LIST: begin
                            if (!is_empty) n_state = deq_pkg::S_LIST;
                        end
                        default: ;
                    endcase
                end
            end
            deq_pkg::S_POP: begin
                if (out_free) n_state = deq_pkg::S_IDLE;
            end
            deq_pkg::S_LIST: begin
                if (out_free && list_done) n_state = deq_pkg::S_IDLE;
            end
            default: n_state = deq_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and result words
    // Push writes and pop reads happen at the accept edge; reads and writes
    // never share a cycle, so a read always sees the latest write.
    // ------------------------------------------------------------------
    assign o_ready = (r_state == deq_pkg::S_IDLE) && out_free;

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        mem_addr = r_front;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        n_word   = '0;
        n_status = deq_pkg::ST_OK;
        n_last   = 1'b1;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode) inside
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                n_status = deq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_opcode == deq_pkg::OP_PUSH_FRONT) begin
                                    mem_addr = front_dec;
                                    n_front  = front_dec;
                                end else begin
                                    mem_addr = slot_addr;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                load_out = 1'b1;
                                n_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                if (i_opcode == deq_pkg::OP_POP_FRONT) begin
                                    mem_addr = r_front;
                                    n_front  = front_inc;
                                end else begin
                                    mem_addr = slot_addr;
                                end
                            end
                        end
                        deq_pkg::OP_LIST: begin
                            if (is_empty) begin
                                load_out = 1'b1;
                                n_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                mem_addr = r_front;
                                n_idx    = '0;
                            end
                        end
                        // unknown opcode: plain acknowledge
                        default: load_out = 1'b1;
                    endcase
                end
            end
            deq_pkg::S_POP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_word   = r_rd_data;
                end
            end
            deq_pkg::S_LIST: begin
                // read data holds while the output stalls
                if (out_free) begin
                    load_out = 1'b1;
                    n_word   = r_rd_data;
                    n_last   = list_done;
                    if (!list_done) begin
                        rd_en    = 1'b1;
                        mem_addr = slot_addr;
                        n_idx    = r_idx + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign occ_x = XW'(n_count);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_word   <= n_word;
            r_status <= n_status;
            r_last   <= n_last;
            r_occ    <= occ_x[deq_pkg::W_OCC-1:0];
        end
    end

    // ring store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[mem_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_word      = r_word;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_occupancy = r_occ;

endmodule

// ===== sv/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound into the core module.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_assert.svh"

module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [deq_pkg::W_OPC-1:0]         i_opcode,
    input logic signed [deq_pkg::W_WORD-1:0] i_value,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [deq_pkg::W_WORD-1:0] o_word,
    input logic [deq_pkg::W_STAT-1:0]        o_status,
    input logic                              o_last,
    input logic [deq_pkg::W_OCC-1:0]         o_occupancy
);

    logic in_seen;
    assign in_seen = i_valid || (i_opcode != '0) || (i_value != '0);

    // occupancy bounded by the ring size (only meaningful below the mask)
    `DEQ_ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, !in_seen || !o_valid || (DEPTH > 31) || (32'(o_occupancy) <= 32'(DEPTH)) || !o_valid, "occupancy above depth")

    // a refused push carries no word and ends its item
    `DEQ_ASSERT_ALWAYS(a_full_shape, i_clk, i_rst_n, !(o_valid && (o_status == deq_pkg::ST_FULL)) || ((o_word == '0) && o_last), "refused push result malformed")

    // empty result: no word, empty queue, single result
    `DEQ_ASSERT_ALWAYS(a_empty_shape, i_clk, i_rst_n, !(o_valid && (o_status == deq_pkg::ST_EMPTY)) || ((o_word == '0) && (o_occupancy == '0) && o_last), "empty result malformed")

    // no new item taken while a list walk is still mid-stream
    `DEQ_ASSERT_ALWAYS(a_list_block, i_clk, i_rst_n, !(o_valid && !o_last) || !o_ready, "input accepted during list walk")

    // a stalled result holds
    `DEQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_word) && $stable(o_last), "stalled result changed")

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_opcode    (i_opcode),
    .i_value     (i_value),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_word      (o_word),
    .o_status    (o_status),
    .o_last      (o_last),
    .o_occupancy (o_occupancy)
);

// ===== tb/sv/double_ended_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both channels of the deque core. Keeps its own copy of the ring
// and predicts every result word, then compares it with what the core emits.
// ----------------------------------------------------------------------------
module double_ended_queue_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [W_OPC-1:0]         i_opcode,
    input  logic signed [W_WORD-1:0] i_value,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic signed [W_WORD-1:0] i_word,
    input  logic [W_STAT-1:0]        i_status,
    input  logic                     i_last,
    input  logic [W_OCC-1:0]         i_occupancy,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_full_seen,
    output int                       o_empty_seen
);

    typedef struct {
        logic signed [W_WORD-1:0] word;
        t_status                  status;
        logic                     last;
        logic [W_OCC-1:0]         occ;
    } t_deq_reply;

    // shadow of the core's ring
    logic signed [W_WORD-1:0] ring [DEPTH];
    int                       head;
    int                       fill;

    t_deq_reply replies [$];
    int         pend_count;
    int         err_count;
    int         res_count;
    int         full_count;
    int         empty_count;

    assign o_errors     = err_count;
    assign o_pending    = pend_count;
    assign o_results    = res_count;
    assign o_full_seen  = full_count;
    assign o_empty_seen = empty_count;

    task automatic report_mismatch(input string field, input longint want, input longint got);
        err_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Works out the result words for one accepted command and queues them.
    task automatic predict_reply(input logic [W_OPC-1:0] op,
                                 input logic signed [W_WORD-1:0] val);
        t_deq_reply r;
        r.word   = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    head       = (head + DEPTH - 1) % DEPTH;
                    ring[head] = val;
                    fill++;
                end else begin
                    ring[(head + fill) % DEPTH] = val;
                    fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (op == OP_POP_FRONT) begin
                    r.word = ring[head];
                    head   = (head + 1) % DEPTH;
                    fill--;
                end else begin
                    r.word = ring[(head + fill - 1) % DEPTH];
                    fill--;
                end
            end
            OP_LIST: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // one word per element, front to back; the final one is pushed below
                    for (int k = 0; k < fill - 1; k++) begin
                        r.word = ring[(head + k) % DEPTH];
                        r.last = 1'b0;
                        r.occ  = W_OCC'(fill);
                        replies.push_back(r);
                    end
                    r.word = ring[(head + fill - 1) % DEPTH];
                    r.last = 1'b1;
                end
            end
            default: ; // reserved opcodes: plain ok word
        endcase
        r.occ = W_OCC'(fill);
        replies.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_deq_reply want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            replies.delete();
            pend_count = 0;
        end else begin
            // result side first: a word can never answer a command taken this edge
            if (i_res_valid && i_res_ready) begin
                res_count++;
                if (i_status == ST_FULL)  full_count++;
                if (i_status == ST_EMPTY) empty_count++;
                if (replies.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word %0d status %0d last %0b occ %0d",
                             $time, i_word, i_status, i_last, i_occupancy);
                end else begin
                    want = replies.pop_front();
                    if (i_word !== want.word)
                        report_mismatch("word", want.word, i_word);
                    if (i_status !== want.status)
                        report_mismatch("status", want.status, i_status);
                    if (i_last !== want.last)
                        report_mismatch("last", want.last, i_last);
                    if (i_occupancy !== want.occ)
                        report_mismatch("occupancy", want.occ, i_occupancy);
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                predict_reply(i_opcode, i_value);
            pend_count = replies.size();
        end
    end

    initial begin
        head        = 0;
        fill        = 0;
        pend_count  = 0;
        err_count   = 0;
        res_count   = 0;
        full_count  = 0;
        empty_count = 0;
    end

endmodule

// ===== tb/sv/double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Drives command words into the deque core and gives the verdict. A directed
// opening covers empty, full and reserved cases; random bursts that fill,
// drain or mix follow, under three settings of channel idling.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
    import deq_pkg::*;

    // reserved opcode space: the core must answer with a plain ok word
    localparam logic [W_OPC-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [W_OPC-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [W_OPC-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [W_WORD-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [W_WORD-1:0] WORD_MAX = 32'sh7fff_ffff;

    // burst flavours of the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    localparam int RAND_PER_PHASE = 45;
    // watchdog limit on silence, far beyond the longest correct one
    localparam int HANDSHAKE_LIMIT = 2000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [W_OPC-1:0]         i_opcode;
    logic signed [W_WORD-1:0] i_value;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [W_WORD-1:0] o_word;
    logic [W_STAT-1:0]        o_status;
    logic                     o_last;
    logic [W_OCC-1:0]         o_occupancy;

    int errors;
    int pending;
    int results;
    int full_seen;
    int empty_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;

    double_ended_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word),
        .o_status    (o_status),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

    double_ended_queue_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_word       (o_word),
        .i_status     (o_status),
        .i_last       (o_last),
        .i_occupancy  (o_occupancy),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side back-pressure: one fresh draw per cycle, at the falling edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: any handshake on either channel restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANDSHAKE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d result words outstanding",
                 $time, HANDSHAKE_LIMIT, pending);
        $display("TEST FAILED");
        $finish;
    end

    // One command word. Random idle cycles go first, then valid rises and is
    // held with the payload until the core takes the word. Returns at the
    // following falling edge with valid still high, so back-to-back words
    // keep valid up without a glitch.
    task automatic send_word(input logic [W_OPC-1:0] op, input logic signed [W_WORD-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Sender holds off until every predicted result word has been taken.
    // Always drops valid before it waits.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int                       r;
        int                       mode;
        int                       burst_left;
        logic [W_OPC-1:0]         op;
        logic signed [W_WORD-1:0] val;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_PUSH_FRONT;
        i_value       = '0;
        i_ready       = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 70;
        words_sent    = 0;
        burst_left    = 0;
        mode          = MODE_MIXED;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed opening ----
        // empty queue: both pops and the list report empty
        send_word(OP_POP_FRONT, 32'sd5);
        send_word(OP_POP_BACK, -32'sd5);
        send_word(OP_LIST, '0);
        // reserved opcodes leave the state alone
        send_word(OP_RSVD_5, WORD_MAX);
        send_word(OP_RSVD_6, WORD_MIN);
        send_word(OP_RSVD_7, -32'sd1);
        // fill to the brim from both ends; extremes go in first so they end
        // up in the middle of the ring and get walked by the list
        for (int k = 0; k < DEPTH_DEF; k++) begin
            case (k)
                0:       val = WORD_MIN;
                1:       val = WORD_MAX;
                2:       val = '0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            send_word(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, val);
        end
        // full store: both pushes refused, then a full-length walk
        send_word(OP_PUSH_FRONT, WORD_MAX);
        send_word(OP_PUSH_BACK, WORD_MIN);
        send_word(OP_LIST, '0);

        // ---- random bursts, three idling phases ----
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            // change idling at a rising edge, away from the ready draw
            @(posedge i_clk);
            case (ph)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            @(negedge i_clk);

            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // bursts that mostly fill or mostly drain reach both ends
                if (burst_left == 0) begin
                    mode       = $urandom_range(MODE_FILL, MODE_MIXED);
                    burst_left = $urandom_range(6, 20);
                end
                burst_left--;

                r = $urandom_range(0, 99);
                if ((mode == MODE_FILL && r < 70) || (mode == MODE_DRAIN && r < 15)
                        || (mode == MODE_MIXED && r < 42))
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if (r < 85)
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else if (r < 97)
                    op = OP_LIST;
                else
                    op = OP_RSVD_5 + W_OPC'($urandom_range(0, 2));

                case ($urandom_range(0, 7))
                    0:       val = WORD_MIN;
                    1:       val = WORD_MAX;
                    2:       val = '0;
                    3:       val = -32'sd1;
                    default: val = $urandom;
                endcase
                send_word(op, val);
            end
        end

        // ---- drain and settle ----
        wait_drained();
        // a stray extra word from the core would show up here
        repeat (20) @(negedge i_clk);

        $display("Sent %0d command words, checked %0d result words over three idling phases",
                 words_sent, results);
        $display("Refused pushes seen: %0d, empty answers seen: %0d", full_seen, empty_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
